>>> rtl/core/cionb_pkg.sv
// shared types, constants and register codes for the CAN I/O node bring-up controller
`timescale 1ns / 1ps

package cionb_pkg;

   // modules the node may report and the width of the expected-type table
   localparam int unsigned MAX_MODULES = 8;
   localparam int unsigned TYPE_SLOTS  = 8;
   localparam int unsigned TYPE_W      = 5;
   localparam int unsigned SLOT_IDX_W  = $clog2(TYPE_SLOTS);

   // configuration port
   localparam int unsigned CSR_DATA_W  = 40;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_NUMBER   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_TYPES  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd3;

   // register values after reset
   localparam logic [6:0]  NODE_NUMBER_RST   = 7'd1;
   localparam logic [3:0]  MODULE_COUNT_RST  = 4'd0;
   localparam logic [39:0] MODULE_TYPES_RST  = 40'd0;
   localparam logic [7:0]  TIMEOUT_LIMIT_RST = 8'd100;

   // request command codes
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_FRAME   = 2'd1;
   localparam logic [1:0] CMD_SEND_DO = 2'd2;

   // command bytes understood by the remote node
   localparam logic [7:0] NODE_CMD_GETSTATUS = 8'h00;
   localparam logic [7:0] NODE_CMD_GETMODULE = 8'h01;

   // frame identifier offsets, all modulo 2^11
   // di = 286 + 4*(node-1) = 282 + 4*node, do = 414 + 4*(node-1) = 410 + 4*node
   localparam logic [10:0] ID_CMD_REQ_OFS  = 11'd1565;
   localparam logic [10:0] ID_CMD_RESP_OFS = 11'd1629;
   localparam logic [10:0] ID_DI_BASE      = 11'd282;
   localparam logic [10:0] ID_DO_BASE      = 11'd410;

   // saturation point of the wait counter
   localparam logic [8:0] WAIT_MAX = 9'd511;

   typedef enum logic [2:0] {
      PH_REQSTATUS  = 3'd0,
      PH_WAITSTATUS = 3'd1,
      PH_REQCOUNT   = 3'd2,
      PH_WAITCOUNT  = 3'd3,
      PH_NEXTMODULE = 3'd4,
      PH_WAITMODULE = 3'd5,
      PH_RUN        = 3'd6,
      PH_ERROR      = 3'd7
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [8:0] wait_ticks;
      logic [3:0] module_cursor;
   } ctx_type;

   typedef struct packed {
      logic [6:0]  node_number;
      logic [3:0]  module_count;
      logic [39:0] module_types;
      logic [7:0]  timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [10:0] frame_id;
      logic [7:0]  rx_byte0;
      logic [7:0]  rx_byte4;
      logic [63:0] output_bits;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [63:0] tx_payload;
      logic [2:0]  link_state;
      logic        running;
   } rsp_type;

endpackage

>>> rtl/core/cionb_req_if.sv
// request channel: tick, received frame or output send command
`timescale 1ns / 1ps

interface cionb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [10:0] frame_id;
   logic [7:0]  rx_byte0;
   logic [7:0]  rx_byte4;
   logic [63:0] output_bits;

   modport source (
      output valid, command, frame_id, rx_byte0, rx_byte4, output_bits,
      input  ready
   );

   modport sink (
      input  valid, command, frame_id, rx_byte0, rx_byte4, output_bits,
      output ready
   );
endinterface

>>> rtl/core/cionb_rsp_if.sv
// response channel: frame to send and link status after each request
`timescale 1ns / 1ps

interface cionb_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_valid;
   logic [10:0] tx_id;
   logic [63:0] tx_payload;
   logic [2:0]  link_state;
   logic        running;

   modport source (
      output valid, tx_valid, tx_id, tx_payload, link_state, running,
      input  ready
   );

   modport sink (
      input  valid, tx_valid, tx_id, tx_payload, link_state, running,
      output ready
   );
endinterface

>>> rtl/core/can_io_node_bringup_controller.sv
// top level of the CAN I/O node bring-up controller
`timescale 1ns / 1ps

// A request is held in the request register, then its response in the response
// register until taken. Throughput: one request per cycle while responses are
// taken; the link state is updated in the step from the request register to the
// response register, so requests follow back to back.
// Reset: synchronous; link goes to request-status, wait counter and module cursor
// clear, and the configuration registers return to their defaults.

module can_io_node_bringup_controller
   import cionb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   cionb_req_if.sink              req_if,
   cionb_rsp_if.source            rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   ctx_type ctx_ff;
   ctx_type ctx_in;
   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    out_free;
   logic    step_fire;
   logic    req_fire;

   // handshake
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign step_fire    = req_valid_ff && out_free;
   assign req_if.ready = !req_valid_ff || out_free;
   assign req_fire     = req_if.valid && req_if.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_number   <= NODE_NUMBER_RST;
         cfg_ff.module_count  <= MODULE_COUNT_RST;
         cfg_ff.module_types  <= MODULE_TYPES_RST;
         cfg_ff.timeout_limit <= TIMEOUT_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_NUMBER:   cfg_ff.node_number   <= csr_wdata[6:0];
            CSR_MODULE_COUNT:  cfg_ff.module_count  <= csr_wdata[3:0];
            CSR_MODULE_TYPES:  cfg_ff.module_types  <= csr_wdata[39:0];
            CSR_TIMEOUT_LIMIT: cfg_ff.timeout_limit <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.command     <= req_if.command;
         req_ff.frame_id    <= req_if.frame_id;
         req_ff.rx_byte0    <= req_if.rx_byte0;
         req_ff.rx_byte4    <= req_if.rx_byte4;
         req_ff.output_bits <= req_if.output_bits;
      end
   end

   // sequencer step
   cionb_step u_step (
      .cur (ctx_ff),
      .cfg (cfg_ff),
      .req (req_ff),
      .nxt (ctx_in),
      .rsp (rsp_in)
   );

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.phase         <= PH_REQSTATUS;
         ctx_ff.wait_ticks    <= '0;
         ctx_ff.module_cursor <= '0;
      end else if (step_fire) begin
         ctx_ff <= ctx_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.tx_valid   = rsp_ff.tx_valid;
   assign rsp_if.tx_id      = rsp_ff.tx_id;
   assign rsp_if.tx_payload = rsp_ff.tx_payload;
   assign rsp_if.link_state = rsp_ff.link_state;
   assign rsp_if.running    = rsp_ff.running;

endmodule

>>> rtl/core/cionb_step.sv
// next link state and outgoing frame for one request
`timescale 1ns / 1ps

module cionb_step
   import cionb_pkg::*;
(
   input  ctx_type cur,
   input  cfg_type cfg,
   input  req_type req,
   output ctx_type nxt,
   output rsp_type rsp
);

   logic [10:0]       id_req;
   logic [10:0]       id_resp;
   logic [10:0]       id_di;
   logic [10:0]       id_do;
   logic [10:0]       node_x4;
   logic              have;
   logic              resp;
   logic              late;
   logic [8:0]        wait_inc;
   logic [TYPE_W-1:0] type_tab [TYPE_SLOTS];
   logic [SLOT_IDX_W-1:0] slot;
   logic              type_ok;
   logic [7:0]        cursor_b0;
   logic [7:0]        cursor_b2;
   phase_type         ph_eff;

   // frame identifiers derived from the node number
   assign node_x4 = {2'b00, cfg.node_number, 2'b00};
   assign id_req  = {4'd0, cfg.node_number} + ID_CMD_REQ_OFS;
   assign id_resp = {4'd0, cfg.node_number} + ID_CMD_RESP_OFS;
   assign id_di   = node_x4 + ID_DI_BASE;
   assign id_do   = node_x4 + ID_DO_BASE;

   // reply detection and wait timeout
   assign have     = (req.command == CMD_FRAME);
   assign resp     = have && (req.frame_id == id_resp);
   assign late     = cur.wait_ticks > {1'b0, cfg.timeout_limit};
   assign wait_inc = (cur.wait_ticks == WAIT_MAX) ? cur.wait_ticks : cur.wait_ticks + 9'd1;

   // expected module type lookup
   always_comb begin
      for (int i = 0; i < TYPE_SLOTS; i++) begin
         type_tab[i] = cfg.module_types[i*TYPE_W +: TYPE_W];
      end
   end

   assign slot    = req.rx_byte0[SLOT_IDX_W-1:0];
   assign type_ok = (req.rx_byte0 < 8'(MAX_MODULES)) &&
                    (req.rx_byte4[TYPE_W-1:0] == type_tab[slot]);

   // module request bytes
   assign cursor_b0 = {4'd0, cur.module_cursor};
   assign cursor_b2 = {4'd0, cur.module_cursor + 4'd1};

   // an error byte overrides the current phase
   assign ph_eff = (have && req.rx_byte0[7]) ? PH_ERROR : cur.phase;

   // handshake sequencer
   always_comb begin
      nxt            = cur;
      rsp.tx_valid   = 1'b0;
      rsp.tx_id      = '0;
      rsp.tx_payload = '0;

      if (req.command == CMD_SEND_DO) begin
         if (cur.phase == PH_RUN) begin
            rsp.tx_valid   = 1'b1;
            rsp.tx_id      = id_do;
            rsp.tx_payload = req.output_bits;
         end
      end else if (req.command == CMD_TICK || req.command == CMD_FRAME) begin
         nxt.phase = ph_eff;
         case (ph_eff)
            PH_REQSTATUS: begin
               rsp.tx_valid   = 1'b1;
               rsp.tx_id      = id_req;
               rsp.tx_payload = {48'd0, NODE_CMD_GETSTATUS, 8'd0};
               nxt.wait_ticks = '0;
               nxt.phase      = PH_WAITSTATUS;
            end
            PH_WAITSTATUS: begin
               nxt.wait_ticks = wait_inc;
               if (late) begin
                  nxt.phase = PH_REQSTATUS;
               end
               if (resp) begin
                  nxt.phase = PH_REQCOUNT;
               end
            end
            PH_REQCOUNT: begin
               rsp.tx_valid   = 1'b1;
               rsp.tx_id      = id_req;
               rsp.tx_payload = {48'd0, NODE_CMD_GETMODULE, 8'd0};
               nxt.wait_ticks = '0;
               nxt.phase      = PH_WAITCOUNT;
            end
            PH_WAITCOUNT: begin
               nxt.module_cursor = '0;
               nxt.wait_ticks    = wait_inc;
               if (late) begin
                  nxt.phase = PH_REQSTATUS;
               end
               if (resp) begin
                  nxt.phase = ({4'd0, cfg.module_count} != req.rx_byte4) ?
                              PH_ERROR : PH_NEXTMODULE;
               end
            end
            PH_NEXTMODULE: begin
               if (cur.module_cursor >= cfg.module_count) begin
                  nxt.phase = PH_RUN;
               end else begin
                  rsp.tx_valid      = 1'b1;
                  rsp.tx_id         = id_req;
                  rsp.tx_payload    = {40'd0, cursor_b2, NODE_CMD_GETMODULE, cursor_b0};
                  nxt.module_cursor = cur.module_cursor + 4'd1;
                  nxt.phase         = PH_WAITMODULE;
               end
               nxt.wait_ticks = '0;
            end
            PH_WAITMODULE: begin
               nxt.wait_ticks = wait_inc;
               if (late) begin
                  nxt.phase = PH_REQSTATUS;
               end
               if (resp) begin
                  nxt.phase = type_ok ? PH_NEXTMODULE : PH_REQSTATUS;
               end
            end
            PH_RUN: begin
               nxt.wait_ticks = wait_inc;
               if (late) begin
                  nxt.phase = PH_REQSTATUS;
               end
               // DI frame feeds the watchdog
               if (have && req.frame_id == id_di) begin
                  nxt.wait_ticks = '0;
               end
            end
            default: begin
               nxt.phase = PH_REQSTATUS;
            end
         endcase
      end

      rsp.link_state = nxt.phase;
      rsp.running    = (nxt.phase == PH_RUN);
   end

endmodule

>>> tb/tb_can_io_node_bringup_controller.sv
// self-checking testbench for the CAN I/O node bring-up controller
`timescale 1ns / 1ps

module tb_can_io_node_bringup_controller;
   import cionb_pkg::*;

   // frame identifier bases of the node protocol
   localparam int unsigned CMD_REQ_BASE  = 1565;
   localparam int unsigned CMD_RESP_BASE = 1629;
   localparam int unsigned DI_FIRST      = 286;
   localparam int unsigned DO_FIRST      = 414;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;

   // receiver hold-off: when it starts and how long it lasts
   localparam int unsigned HOLD_AFTER  = 300;
   localparam int unsigned HOLD_CYCLES = 64;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cionb_req_if req_if();
   cionb_rsp_if rsp_if();

   can_io_node_bringup_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // link state as predicted, plus a shadow of the configuration registers
   cfg_type    cfg;
   phase_type  link_phase = PH_REQSTATUS;
   logic [8:0] wait_count = '0;
   logic [3:0] module_ptr = '0;

   req_type     pending_requests[$];
   rsp_type     link_results[$];
   req_type     offered;
   rsp_type     due;
   int unsigned n_queued     = 0;
   int unsigned results_seen = 0;
   int unsigned n_fail       = 0;
   int unsigned phase_items  = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;
   bit          no_gaps      = 1'b0;

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // identifiers derived from the node number
   function automatic logic [10:0] cmd_req_id();
      return 11'(CMD_REQ_BASE + cfg.node_number);
   endfunction

   function automatic logic [10:0] cmd_resp_id();
      return 11'(CMD_RESP_BASE + cfg.node_number);
   endfunction

   function automatic logic [10:0] di_id();
      return 11'(DI_FIRST + 4 * cfg.node_number - 4);
   endfunction

   function automatic logic [10:0] do_id();
      return 11'(DO_FIRST + 4 * cfg.node_number - 4);
   endfunction

   // timeout is judged on the count before it advances; the count saturates
   function automatic logic wait_expired();
      logic late;
      late = wait_count > {1'b0, cfg.timeout_limit};
      if (wait_count != WAIT_MAX) wait_count = wait_count + 9'd1;
      return late;
   endfunction

   // one request through the bring-up state machine
   function automatic rsp_type predict_link(req_type r);
      rsp_type    res;
      logic       have;
      logic       resp;
      logic       match;
      logic [4:0] want;
      res  = '0;
      have = r.command == CMD_FRAME;
      resp = have && r.frame_id == cmd_resp_id();
      if (r.command == CMD_SEND_DO) begin
         if (link_phase == PH_RUN) begin
            res.tx_valid   = 1'b1;
            res.tx_id      = do_id();
            res.tx_payload = r.output_bits;
         end
      end else if (r.command != CMD_UNUSED) begin
         // an error mark overrides the current phase
         if (have && r.rx_byte0[7]) link_phase = PH_ERROR;
         case (link_phase)
            PH_REQSTATUS: begin
               res.tx_valid   = 1'b1;
               res.tx_id      = cmd_req_id();
               res.tx_payload = {48'd0, NODE_CMD_GETSTATUS, 8'd0};
               wait_count     = '0;
               link_phase     = PH_WAITSTATUS;
            end
            PH_WAITSTATUS: begin
               if (wait_expired()) link_phase = PH_REQSTATUS;
               if (resp) link_phase = PH_REQCOUNT;
            end
            PH_REQCOUNT: begin
               res.tx_valid   = 1'b1;
               res.tx_id      = cmd_req_id();
               res.tx_payload = {48'd0, NODE_CMD_GETMODULE, 8'd0};
               wait_count     = '0;
               link_phase     = PH_WAITCOUNT;
            end
            PH_WAITCOUNT: begin
               module_ptr = '0;
               if (wait_expired()) link_phase = PH_REQSTATUS;
               if (resp) begin
                  if ({4'd0, cfg.module_count} != r.rx_byte4) link_phase = PH_ERROR;
                  else link_phase = PH_NEXTMODULE;
               end
            end
            PH_NEXTMODULE: begin
               if (module_ptr >= cfg.module_count) begin
                  link_phase = PH_RUN;
               end else begin
                  res.tx_valid   = 1'b1;
                  res.tx_id      = cmd_req_id();
                  res.tx_payload = {32'd0, 8'd0, 8'(module_ptr + 1), NODE_CMD_GETMODULE,
                                    8'(module_ptr)};
                  module_ptr     = module_ptr + 4'd1;
                  link_phase     = PH_WAITMODULE;
               end
               wait_count = '0;
            end
            PH_WAITMODULE: begin
               if (wait_expired()) link_phase = PH_REQSTATUS;
               if (resp) begin
                  // indexes past the type table never match
                  match = 1'b0;
                  if (r.rx_byte0 < MAX_MODULES) begin
                     want  = cfg.module_types[5 * r.rx_byte0 +: 5];
                     match = r.rx_byte4[4:0] == want;
                  end
                  if (match) link_phase = PH_NEXTMODULE;
                  else link_phase = PH_REQSTATUS;
               end
            end
            PH_RUN: begin
               // watchdog: a DI frame clears the count but cannot undo a restart
               if (wait_expired()) link_phase = PH_REQSTATUS;
               if (have && r.frame_id == di_id()) wait_count = '0;
            end
            default: link_phase = PH_REQSTATUS;
         endcase
      end
      res.link_state = link_phase;
      res.running    = link_phase == PH_RUN;
      return res;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_request(logic [1:0] command, logic [10:0] frame_id,
                                         logic [7:0] byte0, logic [7:0] byte4,
                                         logic [63:0] bits);
      req_type r;
      r.command     = command;
      r.frame_id    = frame_id;
      r.rx_byte0    = byte0;
      r.rx_byte4    = byte4;
      r.output_bits = bits;
      pending_requests.push_back(r);
      n_queued++;
      phase_items++;
   endfunction

   function automatic void queue_tick();
      queue_request(CMD_TICK, 11'($urandom), 8'($urandom), 8'($urandom), rand_word());
   endfunction

   function automatic void queue_frame(logic [10:0] id, logic [7:0] byte0, logic [7:0] byte4);
      queue_request(CMD_FRAME, id, byte0, byte4, rand_word());
   endfunction

   // stray traffic: any command, any identifier, sometimes an error mark
   function automatic void queue_noise();
      logic [7:0] b0;
      b0 = 8'($urandom);
      if ($urandom_range(0, 3) != 0) b0[7] = 1'b0;
      queue_request(2'($urandom), 11'($urandom), b0, 8'($urandom), rand_word());
   endfunction

   // occasional noise and extra ticks or stray frames while a reply is awaited
   function automatic void queue_wait_filler(bit clean);
      int unsigned n;
      if (clean) return;
      if ($urandom_range(0, 99) < 8) queue_noise();
      if ($urandom_range(0, 99) >= 20) return;
      // around the limit so that a late reply and a timeout can coincide
      if (cfg.timeout_limit <= 8) n = $urandom_range(1, cfg.timeout_limit + 3);
      else n = $urandom_range(1, 3);
      repeat (n) begin
         if ($urandom_range(0, 1) != 0) queue_tick();
         else queue_frame(11'($urandom), 8'($urandom_range(0, 127)), 8'($urandom));
      end
   endfunction

   // traffic once the link runs: ticks, DI frames, output sends, others
   function automatic void queue_run_traffic(bit clean);
      int unsigned pick;
      logic [7:0]  b0;
      pick = $urandom_range(0, 99);
      b0   = 8'($urandom_range(0, 127));
      if (pick < 35) queue_tick();
      else if (pick < 60) queue_frame(di_id(), b0, 8'($urandom));
      else if (pick < 85)
         queue_request(CMD_SEND_DO, 11'($urandom), 8'($urandom), 8'($urandom), rand_word());
      else if (pick < 95 || clean) queue_frame(11'($urandom), b0, 8'($urandom));
      else queue_noise();
   endfunction

   // full bring-up, with well-formed replies unless clean is clear, then some run traffic
   function automatic void queue_bringup(bit clean);
      logic [7:0]  b4;
      int unsigned span;
      // an error mark puts the link back at request-status from any phase
      queue_frame(11'($urandom), 8'($urandom) | 8'h80, 8'($urandom));
      queue_tick();
      queue_wait_filler(clean);
      queue_frame(cmd_resp_id(), 8'($urandom_range(0, 127)), 8'($urandom));
      queue_tick();
      queue_wait_filler(clean);
      b4 = 8'(cfg.module_count);
      if (!clean && $urandom_range(0, 99) < 5) b4 = 8'($urandom);
      queue_frame(cmd_resp_id(), 8'($urandom_range(0, 127)), b4);
      for (int i = 0; i < cfg.module_count; i++) begin
         queue_tick();
         queue_wait_filler(clean);
         b4 = 8'($urandom);
         if (i < MAX_MODULES) b4[4:0] = cfg.module_types[5 * i +: 5];
         if (!clean && $urandom_range(0, 99) < 6) b4[4:0] = b4[4:0] ^ 5'($urandom_range(1, 31));
         queue_frame(cmd_resp_id(), 8'(i), b4);
         // the node cannot report past the type table
         if (i >= MAX_MODULES) break;
      end
      queue_tick();
      span = $urandom_range(2, 16);
      repeat (span) queue_run_traffic(clean);
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_NODE_NUMBER:   cfg.node_number   = value[6:0];
         CSR_MODULE_COUNT:  cfg.module_count  = value[3:0];
         CSR_MODULE_TYPES:  cfg.module_types  = value[39:0];
         CSR_TIMEOUT_LIMIT: cfg.timeout_limit = value[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // all four registers, with junk above the node number, count and limit fields
   task automatic set_link_config(input logic [6:0] node, input logic [3:0] count,
                                  input logic [39:0] types, input logic [7:0] limit);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'({$urandom, $urandom});
      write_reg(CSR_NODE_NUMBER, {junk[39:7], node});
      write_reg(CSR_MODULE_COUNT, {junk[39:4], count});
      write_reg(CSR_MODULE_TYPES, types);
      write_reg(CSR_TIMEOUT_LIMIT, {junk[39:8], limit});
      phase_items = 0;
   endtask

   // wait until every queued request has its response, then let the pipe settle
   task automatic drain();
      while (results_seen != n_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver, predicting each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) link_results.push_back(predict_link(offered));
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 13)) begin
               offered = pending_requests.pop_front();
               req_if.valid       <= 1'b1;
               req_if.command     <= offered.command;
               req_if.frame_id    <= offered.frame_id;
               req_if.rx_byte0    <= offered.rx_byte0;
               req_if.rx_byte4    <= offered.rx_byte4;
               req_if.output_bits <= offered.output_bits;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= no_gaps || $urandom_range(0, 99) >= 13;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (link_results.size() == 0) begin
            $error("response with no request outstanding");
            n_fail++;
         end else begin
            due = link_results.pop_front();
            if (rsp_if.tx_valid !== due.tx_valid) begin
               $error("tx_valid mismatch: expected %0h, got %0h", due.tx_valid, rsp_if.tx_valid);
               n_fail++;
            end
            if (rsp_if.tx_id !== due.tx_id) begin
               $error("tx_id mismatch: expected %0h, got %0h", due.tx_id, rsp_if.tx_id);
               n_fail++;
            end
            if (rsp_if.tx_payload !== due.tx_payload) begin
               $error("tx_payload mismatch: expected %0h, got %0h",
                      due.tx_payload, rsp_if.tx_payload);
               n_fail++;
            end
            if (rsp_if.link_state !== due.link_state) begin
               $error("link_state mismatch: expected %0d, got %0d",
                      due.link_state, rsp_if.link_state);
               n_fail++;
            end
            if (rsp_if.running !== due.running) begin
               $error("running mismatch: expected %0h, got %0h", due.running, rsp_if.running);
               n_fail++;
            end
         end
      end
   end

   // stimulus
   initial begin
      cfg.node_number     = NODE_NUMBER_RST;
      cfg.module_count    = MODULE_COUNT_RST;
      cfg.module_types    = MODULE_TYPES_RST;
      cfg.timeout_limit   = TIMEOUT_LIMIT_RST;
      req_if.valid        = 1'b0;
      req_if.command      = CMD_TICK;
      req_if.frame_id     = '0;
      req_if.rx_byte0     = '0;
      req_if.rx_byte4     = '0;
      req_if.output_bits  = '0;
      rsp_if.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_NODE_NUMBER;
      csr_wdata           = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset configuration
      queue_request(CMD_UNUSED, '1, '1, '1, '1);
      queue_request(CMD_SEND_DO, '0, '0, '0, '1);       // dropped outside run
      queue_tick();                                     // status request
      queue_frame(cmd_resp_id(), 8'hFF, 8'h00);         // error mark on a real reply
      queue_tick();
      queue_frame(11'h000, 8'h00, 8'h00);               // foreign identifiers
      queue_frame(11'h7FF, 8'h7F, 8'hFF);
      queue_frame(cmd_resp_id(), 8'h00, 8'h00);         // status reply
      queue_tick();                                     // count request
      queue_frame(cmd_resp_id(), 8'h7F, 8'hFF);         // count mismatch
      queue_tick();                                     // error back to request-status
      queue_tick();
      queue_frame(cmd_resp_id(), 8'h00, 8'h00);
      queue_tick();
      queue_frame(cmd_resp_id(), 8'h00, 8'h00);         // count of zero matches
      queue_tick();                                     // into run
      queue_request(CMD_SEND_DO, '1, '1, '1, '1);
      queue_request(CMD_SEND_DO, '0, '0, '0, '0);
      queue_frame(di_id(), 8'h00, 8'h00);
      queue_tick();
      queue_request(CMD_UNUSED, 11'($urandom), 8'($urandom), 8'($urandom), rand_word());
      queue_request(CMD_SEND_DO, 11'($urandom), 8'($urandom), 8'($urandom), rand_word());
      queue_frame(di_id(), 8'h80, 8'h00);               // error mark in run
      phase_items = 0;
      while (phase_items < 30) queue_bringup(1'b0);
      drain();

      // top node number, full table, longest timeout, watchdog expiry in run
      set_link_config(7'd127, 4'd8, 40'({$urandom, $urandom}), 8'd255);
      while (phase_items < 40) queue_bringup(1'b0);
      queue_bringup(1'b1);
      repeat (int'(cfg.timeout_limit) + 5) queue_tick();
      drain();

      // timeout limit of one, back to back with no gaps on either side
      no_gaps = 1'b1;
      set_link_config(7'($urandom_range(1, 126)), 4'($urandom_range(0, 8)),
                      40'({$urandom, $urandom}), 8'd1);
      while (phase_items < 60) queue_bringup(1'b0);
      drain();
      no_gaps = 1'b0;

      // module count beyond the type table
      set_link_config(7'd1, 4'($urandom_range(9, 15)), '1, 8'd2);
      while (phase_items < 40) queue_bringup(1'b0);
      drain();

      set_link_config(7'($urandom_range(1, 127)), 4'($urandom_range(0, 8)),
                      40'({$urandom, $urandom}), 8'($urandom_range(1, 6)));
      while (phase_items < 60) queue_bringup(1'b0);
      drain();

      set_link_config(7'($urandom_range(1, 127)), 4'($urandom_range(0, 8)),
                      40'({$urandom, $urandom}), 8'($urandom_range(1, 255)));
      while (phase_items < 50) queue_bringup(1'b0);
      drain();

      if (link_results.size() != 0) begin
         $error("%0d responses never arrived", link_results.size());
         n_fail++;
      end
      if (n_fail == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/core/cionb_pkg.sv
rtl/core/cionb_req_if.sv
rtl/core/cionb_rsp_if.sv
rtl/core/cionb_step.sv
rtl/core/can_io_node_bringup_controller.sv
tb/tb_can_io_node_bringup_controller.sv
